/* design/lrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrc_pkg - shared types and constants for the LRU key-value cache
// Request and response records, field widths, request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    localparam int KEY_W               = 32;
    localparam int VAL_W               = 32;
    localparam int CAP_W               = 5;
    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             REQ_GET    = 1'b0;
    localparam logic             REQ_PUT    = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;   // -1

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } rsp_t;

endpackage

`default_nettype wire

/* design/lrc_match.sv */
// ----------------------------------------------------------------------------
// lrc_match - parallel key compare and victim select
// One compare lane per slot; the victim is the valid slot of oldest rank.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_match
    import lrc_pkg::*;
#(
    parameter int N      = DEFAULT_MAX_ENTRIES,
    parameter int RANK_W = 4,
    parameter int OCC_W  = 5
)
(
    input  wire logic [KEY_W-1:0]  lookup_key,
    input  wire logic [KEY_W-1:0]  slot_key   [N],
    input  wire logic [N-1:0]      slot_valid,
    input  wire logic [RANK_W-1:0] slot_rank  [N],
    input  wire logic [OCC_W-1:0]  occupancy,
    output logic      [N-1:0]      hit_oh,
    output logic      [N-1:0]      victim_oh
);

    logic [OCC_W-1:0] oldest_rank;

    // ranks of valid slots form 0..occupancy-1, so the oldest is occupancy-1
    assign oldest_rank = occupancy - OCC_W'(1);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit_oh[i]    = slot_valid[i] && (slot_key[i] == lookup_key);
            victim_oh[i] = slot_valid[i] && (occupancy != '0) &&
                           (OCC_W'(slot_rank[i]) == oldest_rank);
        end
    end

endmodule

`default_nettype wire

/* design/lrc_store.sv */
// ----------------------------------------------------------------------------
// lrc_store - slot storage and single-pass request update
// Holds keys, values, valid bits, recency ranks and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_store
    import lrc_pkg::*;
#(
    parameter int N = DEFAULT_MAX_ENTRIES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire req_t             req,
    input  wire logic [CAP_W-1:0] capacity,
    output rsp_t                  rsp
);

    localparam int RANK_W = (N > 1) ? $clog2(N) : 1;
    localparam int OCC_W  = $clog2(N + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [KEY_W-1:0]  slot_key_reg   [N];
    logic [VAL_W-1:0]  slot_value_reg [N];
    logic [N-1:0]      slot_valid_reg, slot_valid_next;
    logic [RANK_W-1:0] slot_rank_reg  [N];
    logic [RANK_W-1:0] slot_rank_next [N];
    logic [OCC_W-1:0]  occ_reg, occ_next;

    logic [N-1:0]      hit_oh, victim_oh, valid_mid, free_oh;
    logic              hit_any, is_put, evict;
    logic [RANK_W-1:0] hit_rank;
    logic [VAL_W-1:0]  hit_value;
    logic [KEY_W-1:0]  victim_key;
    logic [CMP_W-1:0]  cap_ext, eff_cap;

    lrc_match #(
        .N      (N),
        .RANK_W (RANK_W),
        .OCC_W  (OCC_W)
    ) u_match (
        .lookup_key (req.lookup_key),
        .slot_key   (slot_key_reg),
        .slot_valid (slot_valid_reg),
        .slot_rank  (slot_rank_reg),
        .occupancy  (occ_reg),
        .hit_oh     (hit_oh),
        .victim_oh  (victim_oh)
    );

    always_comb
    begin
        hit_rank   = '0;
        hit_value  = '0;
        victim_key = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit_oh[i])
            begin
                hit_rank  = hit_rank | slot_rank_reg[i];
                hit_value = hit_value | slot_value_reg[i];
            end
            if (victim_oh[i])
            begin
                victim_key = victim_key | slot_key_reg[i];
            end
        end
    end

    // capacity clamped to 1..N
    assign cap_ext = CMP_W'(capacity);
    assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                     ((cap_ext > CMP_W'(N)) ? CMP_W'(N) : cap_ext);

    assign hit_any = |hit_oh;
    assign is_put  = (req.req_type == REQ_PUT);
    assign evict   = is_put && !hit_any && (occ_reg != '0) &&
                     (CMP_W'(occ_reg) >= eff_cap);

    // victim leaves first, then the lowest free slot takes the new key
    assign valid_mid = slot_valid_reg & ~(evict ? victim_oh : '0);
    assign free_oh   = ~valid_mid & (valid_mid + N'(1));

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_rank_next  = slot_rank_reg;
        occ_next        = occ_reg;
        if (step)
        begin
            if (hit_any)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (slot_valid_reg[i] && (slot_rank_reg[i] < hit_rank))
                        slot_rank_next[i] = slot_rank_reg[i] + RANK_W'(1);
                    if (hit_oh[i])
                        slot_rank_next[i] = '0;
                end
            end
            else if (is_put)
            begin
                slot_valid_next = valid_mid | free_oh;
                for (int i = 0; i < N; i++)
                begin
                    if (valid_mid[i])
                        slot_rank_next[i] = slot_rank_reg[i] + RANK_W'(1);
                    if (free_oh[i])
                        slot_rank_next[i] = '0;
                end
                occ_next = occ_reg - OCC_W'(evict) + OCC_W'(|free_oh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            occ_reg        <= '0;
            for (int i = 0; i < N; i++)
                slot_rank_reg[i] <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            slot_rank_reg  <= slot_rank_next;
            occ_reg        <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (step && is_put && ((hit_any && hit_oh[i]) || (!hit_any && free_oh[i])))
                slot_value_reg[i] <= req.write_value;
            if (step && is_put && !hit_any && free_oh[i])
                slot_key_reg[i] <= req.lookup_key;
        end
    end

    always_comb
    begin
        rsp.hit         = hit_any;
        rsp.evicted     = evict;
        rsp.evicted_key = evict ? victim_key : '0;
        if (is_put)
            rsp.read_value = '0;
        else if (hit_any)
            rsp.read_value = hit_value;
        else
            rsp.read_value = MISS_VALUE;
    end

`ifndef NO_ASSERTIONS
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_oh))
        else $error("key matched more than one valid slot");

    a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != '0) |-> $onehot(victim_oh))
        else $error("recency ranks do not hold exactly one oldest slot");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(N))
        else $error("occupancy above slot count");

    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_put && !hit_any) |=> (occ_reg != '0) && (slot_valid_reg != '0))
        else $error("insert left the store empty");
`endif

endmodule

`default_nettype wire

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache - fully associative key-value cache, LRU replacement
// Get/put requests in, one response per request out.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: lookup_key, write_value; tuser: req_type
//  m_*     | out | m_tvalid/m_tready  | tdata: read_value, evicted_key;
//          |     |                    | tuser: hit, evicted
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: active_capacity
//
//  One request per cycle sustained while m_tready holds high. The single-pass lookup/update
//  moves a request from the input register into the result register, which drives m_tvalid;
//  the next request sees the new state.
//  Reset clears valid bits, ranks and occupancy at once: no sweep, no wait.
//  A stalled output holds its result; the input register takes one more request,
//  then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
    import lrc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  wire logic [0:0]       s_tuser,   // [0] req_type

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [63:0]      m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic      [1:0]       m_tuser,   // [0] hit, [1] evicted

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data   // active_capacity
);

    logic             in_valid_reg, in_valid_next;
    req_t             in_req_reg;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_rsp_reg;
    logic [CAP_W-1:0] cap_reg;

    logic             s_accept, step;
    rsp_t             step_rsp;

    // the result register can load when empty or being drained this cycle
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_req_reg.req_type    <= s_tuser[0];
            in_req_reg.lookup_key  <= s_tdata[31:0];
            in_req_reg.write_value <= s_tdata[63:32];
        end
        if (step)
            out_rsp_reg <= step_rsp;
    end

    lrc_store #(
        .N (MAX_ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req      (in_req_reg),
        .capacity (cap_reg),
        .rsp      (step_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rsp_reg.evicted_key, out_rsp_reg.read_value};
    assign m_tuser  = {out_rsp_reg.evicted, out_rsp_reg.hit};

endmodule

`default_nettype wire

/* test/lru_response_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_response_scoreboard_pkg - response predictor and checker for the cache
// Tracks the cache contents and recency order, and queues one expected
// response per accepted request for in-order comparison.
// ----------------------------------------------------------------------------

package lru_response_scoreboard_pkg;

    import lrc_pkg::*;

    class lru_response_scoreboard;

        logic [KEY_W-1:0] entry_key   [DEFAULT_MAX_ENTRIES];
        logic [VAL_W-1:0] entry_value [DEFAULT_MAX_ENTRIES];
        bit               entry_used  [DEFAULT_MAX_ENTRIES];
        int               entry_age   [DEFAULT_MAX_ENTRIES];   // 0 = most recent
        int               entry_count;
        logic [CAP_W-1:0] capacity_reg;

        rsp_t pending_responses[$];
        int   mismatches;
        int   requests_predicted;
        int   hits_predicted;
        int   evictions_predicted;

        function new();
            foreach (entry_used[i])
            begin
                entry_key[i]   = '0;
                entry_value[i] = '0;
                entry_used[i]  = 1'b0;
                entry_age[i]   = 0;
            end
            entry_count         = 0;
            capacity_reg        = CAP_RESET;
            mismatches          = 0;
            requests_predicted  = 0;
            hits_predicted      = 0;
            evictions_predicted = 0;
        endfunction

        function void write_capacity(logic [CAP_W-1:0] cap);
            capacity_reg = cap;
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction

        // zero acts as one, anything above the slot count as the slot count
        function int effective_capacity();
            if (capacity_reg < 1)
                return 1;
            if (capacity_reg > DEFAULT_MAX_ENTRIES)
                return DEFAULT_MAX_ENTRIES;
            return int'(capacity_reg);
        endfunction

        function void predict_request(req_t r);
            rsp_t e;
            int   found;
            int   victim;
            int   free_idx;
            int   old_age;

            e     = '0;
            found = -1;
            foreach (entry_used[i])
                if (found < 0 && entry_used[i] && entry_key[i] == r.lookup_key)
                    found = i;

            if (found >= 0)
            begin
                e.hit = 1'b1;
                if (r.req_type == REQ_PUT)
                    entry_value[found] = r.write_value;
                else
                    e.read_value = entry_value[found];
                // promote: everything more recent than the hit ages by one
                old_age = entry_age[found];
                foreach (entry_used[i])
                    if (entry_used[i] && entry_age[i] < old_age)
                        entry_age[i]++;
                entry_age[found] = 0;
            end
            else if (r.req_type == REQ_GET)
            begin
                e.read_value = MISS_VALUE;
            end
            else
            begin
                // evict the oldest entry first, then insert into the first free slot
                if (entry_count >= effective_capacity() && entry_count > 0)
                begin
                    victim = -1;
                    foreach (entry_used[i])
                        if (entry_used[i] && (victim < 0 || entry_age[i] > entry_age[victim]))
                            victim = i;
                    e.evicted           = 1'b1;
                    e.evicted_key       = entry_key[victim];
                    entry_used[victim]  = 1'b0;
                    entry_count--;
                end
                free_idx = -1;
                foreach (entry_used[i])
                    if (free_idx < 0 && !entry_used[i])
                        free_idx = i;
                foreach (entry_used[i])
                    if (entry_used[i])
                        entry_age[i]++;
                entry_key[free_idx]   = r.lookup_key;
                entry_value[free_idx] = r.write_value;
                entry_used[free_idx]  = 1'b1;
                entry_age[free_idx]   = 0;
                entry_count++;
            end

            requests_predicted++;
            if (e.hit)
                hits_predicted++;
            if (e.evicted)
                evictions_predicted++;
            pending_responses.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_responses.size() == 0)
            begin
                $error("response with no request outstanding: hit %0b read 0x%08h",
                       got.hit, got.read_value);
                mismatches++;
                return;
            end
            want = pending_responses.pop_front();
            compare_field("hit", 32'(want.hit), 32'(got.hit));
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
            compare_field("evicted_key", want.evicted_key, got.evicted_key);
        endfunction

    endclass

endpackage

/* test/lru_key_value_cache_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test - self-checking bench for the LRU key-value cache
// Directed get/put sequences at the key and value extremes, then random
// traffic over small key pools per capacity setting, with stalls on both
// stream sides. Every response is checked against an in-bench predictor.
// ----------------------------------------------------------------------------

module lru_key_value_cache_test;

    import lrc_pkg::*;
    import lru_response_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 45;
    localparam int PHASES      = 10;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;

    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;    // [31:0] lookup_key, [63:32] write_value
    logic [0:0]       s_tuser   = '0;    // [0] req_type

    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [63:0]      m_tdata;           // [31:0] read_value, [63:32] evicted_key
    logic [1:0]       m_tuser;           // [0] hit, [1] evicted

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;    // active_capacity

    // percent of cycles each side holds off; changed per phase
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;
    int capacity_writes    = 0;

    lru_response_scoreboard cache_model = new();

    lru_key_value_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Response side: check each accepted response transaction against the
    // oldest prediction, then pick this cycle's ready for the next edge.
    always @(posedge clk)
    begin : rsp_monitor
        rsp_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit         = m_tuser[0];
            got.evicted     = m_tuser[1];
            got.read_value  = m_tdata[31:0];
            got.evicted_key = m_tdata[63:32];
            cache_model.check_response(got);
        end
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic req_t make_req(logic kind, logic [KEY_W-1:0] key,
                                      logic [VAL_W-1:0] value);
        req_t r;
        r.req_type    = kind;
        r.lookup_key  = key;
        r.write_value = value;
        return r;
    endfunction

    // Mostly keys from the phase's pool so hits, overwrites and evictions
    // keep happening; a few fully random keys as noise.
    function automatic req_t random_request(input logic [KEY_W-1:0] pool[$]);
        req_t r;
        r.req_type    = ($urandom_range(0, 99) < 55) ? REQ_PUT : REQ_GET;
        r.lookup_key  = ($urandom_range(0, 99) < 8) ? $urandom
                                                    : pool[$urandom_range(0, pool.size() - 1)];
        r.write_value = $urandom;
        return r;
    endfunction

    // Request side: optional idle gap, then hold the transaction until taken.
    // The predictor is updated at the accepting edge.
    task automatic send_request(input req_t r);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.write_value, r.lookup_key};
        s_tuser  <= r.req_type;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cache_model.predict_request(r);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (cache_model.pending() != 0)
            @(posedge clk);
    endtask

    // Capacity changes only with the pipe empty; short settle covers the
    // two-stage request path.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cache_model.write_capacity(cap);
        cfg_valid <= 1'b0;
        capacity_writes++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
            default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
        endcase
    endtask

    initial
    begin
        logic [KEY_W-1:0] key_pool[$];
        int               phase_caps[PHASES];
        int               pool_target;

        // 16 first, then the clamp extremes, then a drop from a full cache to 3
        phase_caps = '{16, 1, 0, 31, 17, 16, 3, 8, 2, 16};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset capacity, key/value extremes ---
        send_request(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));   // miss on empty
        send_request(make_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_request(make_req(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));   // hit returning -1
        send_request(make_req(REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678));   // overwrite
        send_request(make_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'h0000_0001, 32'h0000_0000));   // miss
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'hDEAD_BEEF));   // get ignores value

        // capacity 1 below an occupancy of 4: each insert evicts exactly one
        write_capacity(5'd1);
        send_request(make_req(REQ_PUT, 32'hA5A5_A5A5, 32'h0F0F_0F0F));
        send_request(make_req(REQ_PUT, 32'h5A5A_5A5A, 32'hF0F0_F0F0));
        send_request(make_req(REQ_GET, 32'hA5A5_A5A5, 32'h0000_0000));
        send_request(make_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));

        // capacity 0 behaves as 1
        write_capacity(5'd0);
        send_request(make_req(REQ_PUT, 32'h0000_0001, 32'h0000_0011));
        send_request(make_req(REQ_PUT, 32'h0000_0002, 32'h0000_0022));
        send_request(make_req(REQ_GET, 32'h0000_0001, 32'h0000_0000));

        // --- random phases, one capacity and one idling pattern each ---
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p][CAP_W-1:0]);
            set_idling(p % 4);

            // pool slightly larger than the live capacity; older keys roll out
            pool_target = (phase_caps[p] < 1) ? 4 :
                          (phase_caps[p] > DEFAULT_MAX_ENTRIES) ? DEFAULT_MAX_ENTRIES + 3 :
                          phase_caps[p] + 3;
            while (key_pool.size() < pool_target)
                key_pool.push_back($urandom);
            while (key_pool.size() > pool_target)
                void'(key_pool.pop_front());

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one mid-phase hold-off until every response is back
                if (p == 5 && n == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_request(random_request(key_pool));
            end
        end

        wait_for_drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests with %0d hits and %0d evictions",
                 cache_model.requests_predicted, cache_model.hits_predicted,
                 cache_model.evictions_predicted);
        $display("over %0d capacity writes (0 to 31) under mixed source and sink stalls",
                 capacity_writes);
        if (cache_model.mismatches == 0 && cache_model.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
